// File: src/mvavg_pkg.sv
`timescale 1ns / 1ps
// Shared types and fixed constants for the boxcar moving-average filter.
// No dependencies; imported by every module of the block.
package mvavg_pkg;

  localparam int SAMPLE_W  = 16;  // input sample width
  localparam int AVG_W     = 16;  // output average width
  localparam int CFG_W     = 8;   // window_length register width
  localparam int CFG_RESET = 10;  // window_length after reset

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_UPDATE,
    FR_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_RUN,
    DV_HOLD
  } div_state_e;

endpackage

// File: src/moving_average_filter_core.sv
`timescale 1ns / 1ps
// Boxcar moving-average filter, top level.
// Depends on mvavg_pkg, mvavg_front, mvavg_queue and mvavg_divider.
//
//   port group     | dir | tdata bits (low to high)
//   ---------------+-----+--------------------------
//   s_axis_*       | in  | [15:0] sample
//   m_axis_*       | out | [15:0] average
//   cfg_we_i/wdata | in  | [7:0]  window_length, write clears the window
//
// The front end takes one beat at a time and stays busy until its total is
// pushed; the serial divider is slower still and sets the sustained rate.
// Reset (and any window_length write) clears total and position at once;
// ring slots read as zero until the pointer first wraps, so no clearing pass.
// A two-entry queue lets the front end keep taking beats while m_axis stalls.
module moving_average_filter_core #(
  parameter int MAX_TAPS = 128
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mvavg_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [mvavg_pkg::SAMPLE_W-1:0] s_axis_tdata,   // [15:0] sample
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [mvavg_pkg::AVG_W-1:0]    m_axis_tdata    // [15:0] average
);
  import mvavg_pkg::*;

  localparam int LEN_W = $clog2(MAX_TAPS + 1);
  localparam int TOT_W = SAMPLE_W + $clog2(MAX_TAPS);
  localparam int Q_W   = TOT_W + LEN_W;

  logic             push_valid, push_ready;
  logic [TOT_W-1:0] push_total;
  logic [LEN_W-1:0] push_len;
  logic             pop_valid, pop_ready;
  logic [Q_W-1:0]   pop_data;

  mvavg_front #(
    .MAX_TAPS(MAX_TAPS),
    .LEN_W   (LEN_W),
    .TOT_W   (TOT_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_sample_i  (s_axis_tdata),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_total_o(push_total),
    .push_len_o  (push_len)
  );

  mvavg_queue #(
    .WIDTH(Q_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i ({push_len, push_total}),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  mvavg_divider #(
    .LEN_W(LEN_W),
    .TOT_W(TOT_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pop_valid),
    .in_ready_o (pop_ready),
    .in_total_i (pop_data[TOT_W-1:0]),
    .in_len_i   (pop_data[Q_W-1:TOT_W]),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_average_o(m_axis_tdata)
  );

  // front end handles one sample at a time
  a_front_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("front end took a beat while still busy");

  // a pushed total leaves the front end idle-bound, never pushed twice
  a_single_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid && push_ready |=> !push_valid)
    else $error("front end pushed the same total twice");

  // divider is busy right after taking a queue entry
  a_divider_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_valid && pop_ready |=> !pop_ready)
    else $error("divider accepted a second entry while running");

endmodule

// File: src/mvavg_front.sv
`timescale 1ns / 1ps
// Front end: takes sample beats, swaps them into the sample ring and keeps the
// running total. Depends on mvavg_pkg.
module mvavg_front #(
  parameter int MAX_TAPS = 128,
  parameter int LEN_W    = 8,
  parameter int TOT_W    = 23
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mvavg_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  logic [mvavg_pkg::SAMPLE_W-1:0] s_sample_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output logic [TOT_W-1:0]              push_total_o,
  output logic [LEN_W-1:0]              push_len_o
);
  import mvavg_pkg::*;

  localparam int PTR_W = $clog2(MAX_TAPS);
  localparam int LEN_RST_INT = (CFG_RESET > MAX_TAPS) ? MAX_TAPS : CFG_RESET;
  localparam logic [LEN_W-1:0] LEN_RST = LEN_W'(LEN_RST_INT);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TAPS);
  localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

  front_state_e state_q, state_d;

  logic [SAMPLE_W-1:0] ring [MAX_TAPS];
  logic [SAMPLE_W-1:0] rd_data_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic [SAMPLE_W-1:0] stale;
  logic [TOT_W-1:0]    total_q, total_d;
  logic [PTR_W-1:0]    pos_q, pos_d;
  logic [LEN_W-1:0]    pos_inc;
  logic [LEN_W-1:0]    len_q, len_cfg;
  logic                wrapped_q, wrapped_d;
  logic                ring_re, ring_we;
  logic                s_fire;

  assign s_fire = s_valid_i && s_ready_o;

  // zero means one, anything past the ring depth saturates
  always_comb begin
    if (cfg_wdata_i == '0) begin
      len_cfg = LEN_ONE;
    end else if (int'(cfg_wdata_i) > MAX_TAPS) begin
      len_cfg = LEN_MAX;
    end else begin
      len_cfg = LEN_W'(cfg_wdata_i);
    end
  end

  // Writes go in order from slot 0, so the slot under the pointer holds a
  // real sample only once the pointer has wrapped since the last clear.
  assign stale   = wrapped_q ? rd_data_q : '0;
  assign pos_inc = LEN_W'(pos_q) + LEN_ONE;

  always_comb begin
    state_d = state_q;
    case (state_q)
      FR_IDLE:   if (s_fire) state_d = FR_UPDATE;
      FR_UPDATE: state_d = FR_PUSH;
      FR_PUSH:   if (push_ready_i) state_d = FR_IDLE;
      default:   state_d = FR_IDLE;
    endcase
  end

  always_comb begin
    s_ready_o    = 1'b0;
    push_valid_o = 1'b0;
    ring_re      = 1'b0;
    ring_we      = 1'b0;
    case (state_q)
      FR_IDLE: begin
        s_ready_o = 1'b1;
        ring_re   = s_valid_i;
      end
      FR_UPDATE: ring_we = 1'b1;
      FR_PUSH:   push_valid_o = 1'b1;
      default: begin
        s_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    total_d   = total_q;
    pos_d     = pos_q;
    wrapped_d = wrapped_q;
    if (ring_we) begin
      total_d = total_q - TOT_W'(stale) + TOT_W'(sample_q);
      if (pos_inc >= len_q) begin
        pos_d     = '0;
        wrapped_d = 1'b1;
      end else begin
        pos_d = PTR_W'(pos_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FR_IDLE;
      total_q   <= '0;
      pos_q     <= '0;
      wrapped_q <= 1'b0;
      len_q     <= LEN_RST;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        total_q   <= '0;
        pos_q     <= '0;
        wrapped_q <= 1'b0;
        len_q     <= len_cfg;
      end else begin
        total_q   <= total_d;
        pos_q     <= pos_d;
        wrapped_q <= wrapped_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      sample_q <= s_sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring[pos_q] <= sample_q;
    end
    if (ring_re) begin
      rd_data_q <= ring[pos_q];
    end
  end

  assign push_total_o = total_q;
  assign push_len_o   = len_q;

endmodule

// File: src/mvavg_queue.sv
`timescale 1ns / 1ps
// Two-entry queue that decouples the front end from the divider.
// Depends on mvavg_pkg only by convention; carries an opaque word.
module mvavg_queue #(
  parameter int WIDTH = 31
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  import mvavg_pkg::*;

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: src/mvavg_divider.sv
`timescale 1ns / 1ps
// Back end: restoring divider, one quotient bit per cycle, plus the output
// register that holds a finished average. Depends on mvavg_pkg.
module mvavg_divider #(
  parameter int LEN_W = 8,
  parameter int TOT_W = 23
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [TOT_W-1:0]          in_total_i,
  input  logic [LEN_W-1:0]          in_len_i,
  output logic                      m_valid_o,
  input  logic                      m_ready_i,
  output logic [mvavg_pkg::AVG_W-1:0] m_average_o
);
  import mvavg_pkg::*;

  localparam int CNT_W = $clog2(TOT_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TOT_W - 1);

  div_state_e state_q, state_d;

  logic [TOT_W-1:0] quo_q;
  logic [LEN_W-1:0] rem_q;
  logic [LEN_W-1:0] div_q;
  logic [CNT_W-1:0] cnt_q;
  logic [LEN_W:0]   trial;
  logic             fits;
  logic             load_in, step, load_out;
  logic             out_valid_q;
  logic [AVG_W-1:0] out_q;

  // remainder stays below the divisor, so the trial needs one extra bit
  assign trial = {rem_q, quo_q[TOT_W-1]};
  assign fits  = (trial >= {1'b0, div_q});

  always_comb begin
    state_d = state_q;
    case (state_q)
      DV_IDLE: if (in_valid_i) state_d = DV_RUN;
      DV_RUN:  if (cnt_q == '0) state_d = DV_HOLD;
      DV_HOLD: if (!out_valid_q || m_ready_i) state_d = DV_IDLE;
      default: state_d = DV_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    load_in    = 1'b0;
    step       = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      DV_IDLE: begin
        in_ready_o = 1'b1;
        load_in    = in_valid_i;
      end
      DV_RUN:  step     = 1'b1;
      DV_HOLD: load_out = !out_valid_q || m_ready_i;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= DV_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      quo_q <= in_total_i;
      rem_q <= '0;
      div_q <= in_len_i;
      cnt_q <= CNT_LAST;
    end else if (step) begin
      quo_q <= {quo_q[TOT_W-2:0], fits};
      rem_q <= fits ? LEN_W'(trial - {1'b0, div_q}) : LEN_W'(trial);
      cnt_q <= cnt_q - CNT_W'(1);
    end
    if (load_out) begin
      out_q <= quo_q[AVG_W-1:0];
    end
  end

  assign m_valid_o   = out_valid_q;
  assign m_average_o = out_q;

endmodule
